### sv/cslesc_pkg.sv
// Shared types and constants for the C string literal escaper.
package cslesc_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_OUTPUT_FORMAT  = 2'd0;
	localparam logic [1:0] CFG_DOUBLE_PERCENT = 2'd1;
	localparam logic [1:0] CFG_LINEBREAK_MODE = 2'd2;
	localparam logic [1:0] CFG_AUTO_LINEBREAK = 2'd3;

	// Output format codes
	localparam logic [1:0] FMT_TEXT = 2'd0;
	localparam logic [1:0] FMT_HEX  = 2'd1;
	localparam logic [1:0] FMT_OCT  = 2'd2;

	// Line end mode codes
	localparam logic [1:0] LB_KEEP = 2'd0;
	localparam logic [1:0] LB_CRLF = 2'd1;
	localparam logic [1:0] LB_LF   = 2'd2;

	// Characters
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_HEXA   = 8'h37;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_X      = 8'h78;

	// Command slots, emitted in this order
	localparam int NSLOT  = 7;
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SL_OPEN  = 3'd0;
	localparam logic [SLOT_W-1:0] SL_PRE   = 3'd1;
	localparam logic [SLOT_W-1:0] SL_A     = 3'd2;
	localparam logic [SLOT_W-1:0] SL_B     = 3'd3;
	localparam logic [SLOT_W-1:0] SL_C     = 3'd4;
	localparam logic [SLOT_W-1:0] SL_ENDB  = 3'd5;
	localparam logic [SLOT_W-1:0] SL_CLOSE = 3'd6;

	typedef struct packed {
		logic [1:0] output_format;
		logic       double_percent;
		logic [1:0] linebreak_mode;
		logic       auto_linebreak;
	} cfg_t;

	// Token kinds: plain char, backslash pair, numeric escape, text break, escape break
	typedef enum logic [2:0] {
		TK_CHAR,
		TK_ESC2,
		TK_ESCB,
		TK_TBRK,
		TK_EBRK
	} tok_kind_t;

	typedef struct packed {
		logic       en;
		tok_kind_t  kind;
		logic [7:0] ch;
	} tok_t;

	typedef struct packed {
		logic                  hex;
		tok_t [NSLOT-1:0]      slot;
	} cmd_t;

endpackage

### sv/c_string_literal_escaper.sv
// Top level: input byte stream in, quoted C string literal characters out.
// Items wait in the command queue; their characters are registered onto the result ports.
// Throughput: one character per cycle from the sequencer while the result is empty or popped;
// an item gives 1 to 12 characters (typically 1 to 4); items that give none are not queued.
// Items are accepted every cycle while the command queue has room (QUEUE_DEPTH entries).
// Reset: arst_n clears configuration, line state, queue and output valid; no clearing pass.
module c_string_literal_escaper #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       end_of_string,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       literal_done,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data
);

	cslesc_pkg::cfg_t cfg_q;
	cslesc_pkg::cmd_t wr_cmd, head;
	logic             wr_en, rd_en, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cslesc_pkg::CFG_OUTPUT_FORMAT:  cfg_q.output_format  <= cfg_data;
				cslesc_pkg::CFG_DOUBLE_PERCENT: cfg_q.double_percent <= cfg_data[0];
				cslesc_pkg::CFG_LINEBREAK_MODE: cfg_q.linebreak_mode <= cfg_data;
				cslesc_pkg::CFG_AUTO_LINEBREAK: cfg_q.auto_linebreak <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign full = q_full;

	cslesc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.q_full        (q_full),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string),
		.wr_en         (wr_en),
		.wr_cmd        (wr_cmd)
	);

	cslesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_cmd),
		.full    (q_full),
		.rd_en   (rd_en),
		.rd_data (head),
		.empty   (q_empty)
	);

	cslesc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.rd_en        (rd_en),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.literal_done (literal_done),
		.empty        (empty),
		.pop          (pop)
	);

endmodule

### sv/cslesc_front.sv
// Front end: accepts source bytes, tracks line end state and builds token commands.
module cslesc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  cslesc_pkg::cfg_t   cfg,
	input  logic               push,
	input  logic               q_full,
	input  logic [7:0]         data_byte,
	input  logic               byte_valid,
	input  logic               end_of_string,
	output logic               wr_en,
	output cslesc_pkg::cmd_t   wr_cmd
);

	logic open_q, pend_q, prev_q, seen_q;
	logic n_open, n_pend, n_prev, n_seen;
	logic accept, is_text, keep, is_cr, is_lf, auto_br;
	logic [cslesc_pkg::NSLOT-1:0] en_v;
	cslesc_pkg::cmd_t cmd;

	function automatic cslesc_pkg::tok_t mk_tok(cslesc_pkg::tok_kind_t kind, logic [7:0] ch);
		cslesc_pkg::tok_t t;
		t.en   = 1'b1;
		t.kind = kind;
		t.ch   = ch;
		return t;
	endfunction

	assign accept  = push && !q_full;
	assign is_text = !(cfg.output_format == cslesc_pkg::FMT_HEX ||
		cfg.output_format == cslesc_pkg::FMT_OCT);
	assign keep    = !(cfg.linebreak_mode == cslesc_pkg::LB_CRLF ||
		cfg.linebreak_mode == cslesc_pkg::LB_LF);
	assign is_cr   = (data_byte == cslesc_pkg::CH_CR);
	assign is_lf   = (data_byte == cslesc_pkg::CH_LF);
	assign auto_br = cfg.auto_linebreak;

	// Classify the transaction into token slots and next state
	always_comb begin
		cmd     = '0;
		cmd.hex = (cfg.output_format == cslesc_pkg::FMT_HEX);
		n_open  = open_q;
		n_pend  = pend_q;
		n_prev  = prev_q;
		n_seen  = seen_q;
		if (byte_valid || end_of_string) begin
			if (!open_q) begin
				cmd.slot[cslesc_pkg::SL_OPEN] = mk_tok(cslesc_pkg::TK_CHAR, cslesc_pkg::CH_DQUOTE);
			end
			n_open = 1'b1;
		end
		if (byte_valid) begin
			n_seen = 1'b1;
			if (is_text) begin
				if (pend_q && is_lf) begin
					// complete a kept CRLF
					cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESC2, cslesc_pkg::CH_N);
					if (auto_br) begin
						cmd.slot[cslesc_pkg::SL_C] = mk_tok(cslesc_pkg::TK_TBRK, 8'h00);
					end
					n_pend = 1'b0;
					n_prev = 1'b0;
				end else if (!pend_q && prev_q && is_lf) begin
					// drop the LF of a CRLF pair
					n_prev = 1'b0;
				end else begin
					n_pend = 1'b0;
					if (pend_q && keep && auto_br) begin
						cmd.slot[cslesc_pkg::SL_PRE] = mk_tok(cslesc_pkg::TK_TBRK, 8'h00);
					end
					case (data_byte)
						cslesc_pkg::CH_PCT: begin
							cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_CHAR, data_byte);
							if (cfg.double_percent) begin
								cmd.slot[cslesc_pkg::SL_B] = mk_tok(cslesc_pkg::TK_CHAR, data_byte);
							end
						end
						cslesc_pkg::CH_BSL, cslesc_pkg::CH_DQUOTE, cslesc_pkg::CH_SQUOTE: begin
							cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESC2, data_byte);
						end
						cslesc_pkg::CH_CR, cslesc_pkg::CH_LF: begin
							if (is_cr && keep) begin
								cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESC2,
									cslesc_pkg::CH_R);
								n_pend = 1'b1;
							end else begin
								if (cfg.linebreak_mode == cslesc_pkg::LB_CRLF) begin
									cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESC2,
										cslesc_pkg::CH_R);
									cmd.slot[cslesc_pkg::SL_B] = mk_tok(cslesc_pkg::TK_ESC2,
										cslesc_pkg::CH_N);
								end else begin
									cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESC2,
										cslesc_pkg::CH_N);
								end
								if (auto_br) begin
									cmd.slot[cslesc_pkg::SL_C] = mk_tok(cslesc_pkg::TK_TBRK, 8'h00);
								end
							end
						end
						default: begin
							cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_CHAR, data_byte);
						end
					endcase
					n_prev = is_cr;
				end
			end else begin
				n_pend = 1'b0;
				if (!(is_cr && cfg.linebreak_mode == cslesc_pkg::LB_LF)) begin
					if (is_lf && cfg.linebreak_mode == cslesc_pkg::LB_CRLF && seen_q && !prev_q) begin
						cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESCB, cslesc_pkg::CH_CR);
						cmd.slot[cslesc_pkg::SL_B] = mk_tok(cslesc_pkg::TK_ESCB, data_byte);
					end else begin
						cmd.slot[cslesc_pkg::SL_A] = mk_tok(cslesc_pkg::TK_ESCB, data_byte);
						if (data_byte == cslesc_pkg::CH_PCT && cfg.double_percent) begin
							cmd.slot[cslesc_pkg::SL_B] = mk_tok(cslesc_pkg::TK_ESCB, data_byte);
						end
					end
					if (is_lf && auto_br) begin
						cmd.slot[cslesc_pkg::SL_C] = mk_tok(cslesc_pkg::TK_EBRK, 8'h00);
					end
				end
				n_prev = is_cr;
			end
		end
		if (end_of_string) begin
			if (n_pend && is_text && keep && auto_br) begin
				cmd.slot[cslesc_pkg::SL_ENDB] = mk_tok(cslesc_pkg::TK_TBRK, 8'h00);
			end
			cmd.slot[cslesc_pkg::SL_CLOSE] = mk_tok(cslesc_pkg::TK_CHAR, cslesc_pkg::CH_DQUOTE);
			n_open = 1'b0;
			n_pend = 1'b0;
			n_prev = 1'b0;
			n_seen = 1'b0;
		end
	end

	// Collect slot enables
	always_comb begin
		for (int i = 0; i < cslesc_pkg::NSLOT; i++) begin
			en_v[i] = cmd.slot[i].en;
		end
	end

	// Queue only transactions that produce characters
	assign wr_en  = accept && (|en_v);
	assign wr_cmd = cmd;

	// Advance line state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			pend_q <= 1'b0;
			prev_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (accept) begin
			open_q <= n_open;
			pend_q <= n_pend;
			prev_q <= n_prev;
			seen_q <= n_seen;
		end
	end

endmodule

### sv/cslesc_queue.sv
// Command queue between the front end and the character sequencer.
module cslesc_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  cslesc_pkg::cmd_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output cslesc_pkg::cmd_t rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cslesc_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/cslesc_back.sv
// Back end: walks token slots, one character per cycle unless output awaits a pop.
module cslesc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cslesc_pkg::cmd_t head,
	input  logic             q_empty,
	output logic             rd_en,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             literal_done,
	output logic             empty,
	input  logic             pop
);

	logic [cslesc_pkg::NSLOT-1:0]  done_q, en_v, live, low;
	logic [1:0]                    idx_q, last_idx;
	logic [cslesc_pkg::SLOT_W-1:0] cur;
	cslesc_pkg::tok_t              tok;
	logic                          more, tok_last, cmd_last, go;
	logic                          out_valid_q, run_last_q, literal_done_q;
	logic [7:0]                    out_byte_q, ch;

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		logic [7:0] base;
		base = (n < 4'd10) ? cslesc_pkg::CH_ZERO : cslesc_pkg::CH_HEXA;
		return base + {4'd0, n};
	endfunction

	// Find the lowest slot not yet emitted
	always_comb begin
		for (int i = 0; i < cslesc_pkg::NSLOT; i++) begin
			en_v[i] = head.slot[i].en;
		end
		live = en_v & ~done_q;
		low  = live & (~live + cslesc_pkg::NSLOT'(1));
		more = |(live & ~low);
		cur  = '0;
		for (int i = 0; i < cslesc_pkg::NSLOT; i++) begin
			if (low[i]) begin
				cur = cslesc_pkg::SLOT_W'(i);
			end
		end
		tok = head.slot[cur];
	end

	// Pick the character at the current position of the token
	always_comb begin
		ch       = tok.ch;
		last_idx = 2'd0;
		case (tok.kind)
			cslesc_pkg::TK_CHAR: begin
				ch       = tok.ch;
				last_idx = 2'd0;
			end
			cslesc_pkg::TK_ESC2: begin
				ch       = (idx_q == 2'd0) ? cslesc_pkg::CH_BSL : tok.ch;
				last_idx = 2'd1;
			end
			cslesc_pkg::TK_ESCB: begin
				last_idx = 2'd3;
				case (idx_q)
					2'd0: ch = cslesc_pkg::CH_BSL;
					2'd1: ch = head.hex ? cslesc_pkg::CH_X :
						cslesc_pkg::CH_ZERO + {5'd0, 1'b0, tok.ch[7:6]};
					2'd2: ch = head.hex ? hex_digit(tok.ch[7:4]) :
						cslesc_pkg::CH_ZERO + {5'd0, tok.ch[5:3]};
					default: ch = head.hex ? hex_digit(tok.ch[3:0]) :
						cslesc_pkg::CH_ZERO + {5'd0, tok.ch[2:0]};
				endcase
			end
			cslesc_pkg::TK_TBRK: begin
				last_idx = 2'd3;
				case (idx_q)
					2'd1:    ch = cslesc_pkg::CH_CR;
					2'd2:    ch = cslesc_pkg::CH_LF;
					default: ch = cslesc_pkg::CH_DQUOTE;
				endcase
			end
			cslesc_pkg::TK_EBRK: begin
				last_idx = 2'd2;
				ch       = (idx_q == 2'd1) ? cslesc_pkg::CH_LF : cslesc_pkg::CH_DQUOTE;
			end
			default: begin
				ch       = tok.ch;
				last_idx = 2'd0;
			end
		endcase
	end

	assign tok_last = (idx_q == last_idx);
	assign cmd_last = tok_last && !more;
	assign go       = !q_empty && (!out_valid_q || pop);
	assign rd_en    = go && cmd_last;

	// Step through tokens and slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			idx_q  <= '0;
		end else if (go) begin
			if (cmd_last) begin
				done_q <= '0;
				idx_q  <= '0;
			end else if (tok_last) begin
				done_q <= done_q | low;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Hold the output transaction until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_byte_q     <= ch;
			run_last_q     <= cmd_last;
			literal_done_q <= (cur == cslesc_pkg::SL_CLOSE);
		end
	end

	assign empty        = !out_valid_q;
	assign out_byte     = out_byte_q;
	assign run_last     = run_last_q;
	assign literal_done = literal_done_q;

	a_mid_token_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !q_empty)
		else $error("token in progress with no command");

	a_mid_cmd_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q != '0) |-> !q_empty)
		else $error("partly emitted command vanished");

	a_go_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (live != '0))
		else $error("emitting from a command with no slots left");

	a_done_is_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && literal_done_q) |-> (run_last_q && out_byte_q == cslesc_pkg::CH_DQUOTE))
		else $error("closing quote not last or not a quote");

endmodule
